### src/assert_macros.svh
// Assertion macros shared by the shape coverage and blend RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication property on the rising clock, idle while in reset.
`define SCA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define SCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sca_pkg.sv
// Package for the shape coverage alpha blend block: frame limits, register
// indexes, reset values and the structs passed between modules. No dependencies.
`default_nettype none

package sca_pkg;

    // Frame size in pixels
    localparam int FRAME_WIDTH  = 1024;
    localparam int FRAME_HEIGHT = 1024;

    // Field widths
    localparam int PIX_W   = 10;
    localparam int COLOR_W = 8;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;

    // Cosine of zero angle in Q1.14
    localparam logic [15:0] COS_ONE = 16'h4000;

    // Shape selector
    localparam logic SHAPE_RECT = 1'b0;
    localparam logic SHAPE_RING = 1'b1;

    // Full-scale alpha
    localparam logic [COLOR_W-1:0] ALPHA_MAX = 8'hFF;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_SHAPE_MODE = 3'd0,
        REG_CENTER_X   = 3'd1,
        REG_CENTER_Y   = 3'd2,
        REG_EXTENT_A   = 3'd3,
        REG_EXTENT_B   = 3'd4,
        REG_ROT_COS    = 3'd5,
        REG_ROT_SIN    = 3'd6,
        REG_PAINT      = 3'd7
    } sca_reg_idx_t;

    // Configuration register contents
    typedef struct packed {
        logic        shape_mode;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [14:0] extent_a;
        logic [14:0] extent_b;
        logic [15:0] rot_cos;
        logic [15:0] rot_sin;
        logic [31:0] paint;
    } sca_cfg_t;

    // Pipeline stage enables and the stage-3 valid
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en_out;
        logic v3;
    } sca_pipe_t;

endpackage

`default_nettype wire

### src/sca_cfg_regs.sv
// Configuration register file for the shape coverage alpha blend block.
// Depends on sca_pkg for register indexes, reset values and sca_cfg_t.
`default_nettype none

module sca_cfg_regs (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_valid,
    input  wire  [sca_pkg::IDX_W-1:0]   cfg_index,
    input  wire  [sca_pkg::DATA_W-1:0]  cfg_data,
    output sca_pkg::sca_cfg_t           cfg
);
    import sca_pkg::*;

    sca_cfg_t cfg_reg;

    // Write one register per transaction, keeping its low bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shape_mode <= SHAPE_RECT;
            cfg_reg.center_x   <= '0;
            cfg_reg.center_y   <= '0;
            cfg_reg.extent_a   <= '0;
            cfg_reg.extent_b   <= '0;
            cfg_reg.rot_cos    <= COS_ONE;
            cfg_reg.rot_sin    <= '0;
            cfg_reg.paint      <= '0;
        end
        else if (cfg_valid)
        begin
            case (sca_reg_idx_t'(cfg_index))
                REG_SHAPE_MODE: cfg_reg.shape_mode <= cfg_data[0];
                REG_CENTER_X:   cfg_reg.center_x   <= cfg_data[15:0];
                REG_CENTER_Y:   cfg_reg.center_y   <= cfg_data[15:0];
                REG_EXTENT_A:   cfg_reg.extent_a   <= cfg_data[14:0];
                REG_EXTENT_B:   cfg_reg.extent_b   <= cfg_data[14:0];
                REG_ROT_COS:    cfg_reg.rot_cos    <= cfg_data[15:0];
                REG_ROT_SIN:    cfg_reg.rot_sin    <= cfg_data[15:0];
                REG_PAINT:      cfg_reg.paint      <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### src/sca_coverage.sv
// Three-stage pixel-center coverage test: offset, products, compare.
// Depends on sca_pkg for frame limits, shape codes and the shared structs.
`default_nettype none

module sca_coverage (
    input  wire                         clk,
    input  sca_pkg::sca_pipe_t          ctrl,
    input  sca_pkg::sca_cfg_t           cfg,
    input  wire  [sca_pkg::PIX_W-1:0]   pixel_x,
    input  wire  [sca_pkg::PIX_W-1:0]   pixel_y,
    output logic                        hit
);
    import sca_pkg::*;

    localparam logic [12:0] X_LIM = 13'(FRAME_WIDTH);
    localparam logic [12:0] Y_LIM = 13'(FRAME_HEIGHT);

    // Stage 1: Q.4 offsets of the pixel center from the shape center
    logic signed [16:0] px_reg, px_next;
    logic signed [16:0] py_reg, py_next;
    logic               frame_reg, frame_next;

    // Stage 2: rotation products, squares and squared radii
    logic signed [32:0] pxc_reg, pxc_next;
    logic signed [32:0] pys_reg, pys_next;
    logic signed [32:0] pxs_reg, pxs_next;
    logic signed [32:0] pyc_reg, pyc_next;
    logic signed [33:0] sqx_full, sqy_full;
    logic        [31:0] sqx_reg, sqx_next;
    logic        [31:0] sqy_reg, sqy_next;
    logic        [29:0] ro2_reg, ro2_next;
    logic        [29:0] ri2_reg, ri2_next;
    logic               frame2_reg;

    // Stage 3: inside test
    logic signed [33:0] lx, ly, ha, hb;
    logic        [32:0] d2;
    logic               in_rect, in_ring;
    logic               hit_reg, hit_next;

    // Form offsets and the frame check
    always_comb
    begin
        px_next    = $signed({3'b000, pixel_x, 4'b1000})
                     - $signed({cfg.center_x[15], cfg.center_x});
        py_next    = $signed({3'b000, pixel_y, 4'b1000})
                     - $signed({cfg.center_y[15], cfg.center_y});
        frame_next = ({3'b000, pixel_x} < X_LIM) && ({3'b000, pixel_y} < Y_LIM);
    end

    // Multiply offsets by cos/sin and square them
    always_comb
    begin
        pxc_next = 33'(px_reg) * 33'($signed(cfg.rot_cos));
        pys_next = 33'(py_reg) * 33'($signed(cfg.rot_sin));
        pxs_next = 33'(px_reg) * 33'($signed(cfg.rot_sin));
        pyc_next = 33'(py_reg) * 33'($signed(cfg.rot_cos));
        sqx_full = 34'(px_reg) * 34'(px_reg);
        sqy_full = 34'(py_reg) * 34'(py_reg);
        sqx_next = sqx_full[31:0];
        sqy_next = sqy_full[31:0];
        ro2_next = 30'(cfg.extent_a) * 30'(cfg.extent_a);
        ri2_next = 30'(cfg.extent_b) * 30'(cfg.extent_b);
    end

    // Compare rotated coordinates or squared distance; edges count as inside
    always_comb
    begin
        lx      = 34'(pxc_reg) - 34'(pys_reg);
        ly      = 34'(pxs_reg) + 34'(pyc_reg);
        ha      = $signed({5'b00000, cfg.extent_a, 14'b0});
        hb      = $signed({5'b00000, cfg.extent_b, 14'b0});
        in_rect = (lx >= -ha) && (lx <= ha) && (ly >= -hb) && (ly <= hb);
        d2      = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        in_ring = (d2 <= {3'b000, ro2_reg}) && (d2 >= {3'b000, ri2_reg});
        hit_next = frame2_reg && ((cfg.shape_mode == SHAPE_RING) ? in_ring : in_rect);
    end

    // Advance each stage on its enable
    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            frame_reg <= frame_next;
        end
        if (ctrl.en2)
        begin
            pxc_reg    <= pxc_next;
            pys_reg    <= pys_next;
            pxs_reg    <= pxs_next;
            pyc_reg    <= pyc_next;
            sqx_reg    <= sqx_next;
            sqy_reg    <= sqy_next;
            ro2_reg    <= ro2_next;
            ri2_reg    <= ri2_next;
            frame2_reg <= frame_reg;
        end
        if (ctrl.en3)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

`default_nettype wire

### src/sca_blend.sv
// Per-channel alpha blend with truncating divide by 255, and the output mux.
// Depends on sca_pkg and assert_macros.svh.
`default_nettype none

module sca_blend (
    input  wire                          clk,
    input  wire                          rst_n,
    input  sca_pkg::sca_pipe_t           ctrl,
    input  sca_pkg::sca_cfg_t            cfg,
    input  wire  [sca_pkg::COLOR_W-1:0]  background_red,
    input  wire  [sca_pkg::COLOR_W-1:0]  background_green,
    input  wire  [sca_pkg::COLOR_W-1:0]  background_blue,
    input  wire                          hit,
    output logic [sca_pkg::COLOR_W-1:0]  out_red,
    output logic [sca_pkg::COLOR_W-1:0]  out_green,
    output logic [sca_pkg::COLOR_W-1:0]  out_blue,
    output logic                         covered
);
    import sca_pkg::*;

    `include "assert_macros.svh"

    logic [7:0]  alpha, alpha_inv;

    // Stage 1: background
    logic [7:0]  bg1_r_reg, bg1_g_reg, bg1_b_reg;
    // Stage 2: weighted sums
    logic [15:0] n_r_reg, n_r_next, n_g_reg, n_g_next, n_b_reg, n_b_next;
    logic [7:0]  bg2_r_reg, bg2_g_reg, bg2_b_reg;
    // Stage 3: quotients
    logic [16:0] t_r, t_g, t_b;
    logic [7:0]  q_r_reg, q_r_next, q_g_reg, q_g_next, q_b_reg, q_b_next;
    logic [7:0]  bg3_r_reg, bg3_g_reg, bg3_b_reg;
    // Output
    logic [7:0]  out_red_reg, out_green_reg, out_blue_reg;
    logic        covered_reg;

    // Weight paint and background by alpha
    always_comb
    begin
        alpha     = cfg.paint[7:0];
        alpha_inv = ALPHA_MAX - alpha;
        n_r_next  = 16'(cfg.paint[31:24]) * 16'(alpha) + 16'(bg1_r_reg) * 16'(alpha_inv);
        n_g_next  = 16'(cfg.paint[23:16]) * 16'(alpha) + 16'(bg1_g_reg) * 16'(alpha_inv);
        n_b_next  = 16'(cfg.paint[15:8])  * 16'(alpha) + 16'(bg1_b_reg) * 16'(alpha_inv);
    end

    // Divide by 255: floor(n/255) = (n + 1 + n/256) / 256 for n up to 255*255
    always_comb
    begin
        t_r      = {1'b0, n_r_reg} + 17'd1 + 17'(n_r_reg[15:8]);
        t_g      = {1'b0, n_g_reg} + 17'd1 + 17'(n_g_reg[15:8]);
        t_b      = {1'b0, n_b_reg} + 17'd1 + 17'(n_b_reg[15:8]);
        q_r_next = t_r[15:8];
        q_g_next = t_g[15:8];
        q_b_next = t_b[15:8];
    end

    // Advance stages and select blended or background color
    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            bg1_r_reg <= background_red;
            bg1_g_reg <= background_green;
            bg1_b_reg <= background_blue;
        end
        if (ctrl.en2)
        begin
            n_r_reg   <= n_r_next;
            n_g_reg   <= n_g_next;
            n_b_reg   <= n_b_next;
            bg2_r_reg <= bg1_r_reg;
            bg2_g_reg <= bg1_g_reg;
            bg2_b_reg <= bg1_b_reg;
        end
        if (ctrl.en3)
        begin
            q_r_reg   <= q_r_next;
            q_g_reg   <= q_g_next;
            q_b_reg   <= q_b_next;
            bg3_r_reg <= bg2_r_reg;
            bg3_g_reg <= bg2_g_reg;
            bg3_b_reg <= bg2_b_reg;
        end
        if (ctrl.en_out)
        begin
            out_red_reg   <= hit ? q_r_reg : bg3_r_reg;
            out_green_reg <= hit ? q_g_reg : bg3_g_reg;
            out_blue_reg  <= hit ? q_b_reg : bg3_b_reg;
            covered_reg   <= hit;
        end
    end

    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign covered   = covered_reg;

    // An uncovered pixel passes its background through
    `SCA_ASSERT_NEXT(a_pass_through, clk, rst_n, ctrl.en_out && ctrl.v3 && !hit, out_red_reg == $past(bg3_r_reg) && out_green_reg == $past(bg3_g_reg) && out_blue_reg == $past(bg3_b_reg), "uncovered pixel changed color")
    // Full alpha gives the paint color
    `SCA_ASSERT_NEXT(a_alpha_full, clk, rst_n, ctrl.en_out && ctrl.v3 && hit && cfg.paint[7:0] == ALPHA_MAX, out_red_reg == $past(cfg.paint[31:24]) && out_green_reg == $past(cfg.paint[23:16]) && out_blue_reg == $past(cfg.paint[15:8]), "full alpha did not give paint color")
    // Zero alpha gives the background even when covered
    `SCA_ASSERT_NEXT(a_alpha_zero, clk, rst_n, ctrl.en_out && ctrl.v3 && cfg.paint[7:0] == 8'h00, out_red_reg == $past(bg3_r_reg) && out_green_reg == $past(bg3_g_reg) && out_blue_reg == $past(bg3_b_reg), "zero alpha changed color")

endmodule

`default_nettype wire

### src/shape_coverage_alpha_blend.sv
// Top level of the shape coverage alpha blend block: stream ports, pipeline
// valids and stage enables. Depends on sca_pkg, sca_cfg_regs, sca_coverage,
// sca_blend and assert_macros.svh.
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  pixel and background color
// m_axis    out        m_axis_tvalid / m_axis_tready  result color, covered flag
// cfg       in         cfg_valid / cfg_ready          register index and value
//
// Four register stages: offset, multiply, compare and divide, output; one pixel
// is accepted every cycle unless all stages are full and m_axis stalls.
// The multiply stage (rotation products and squares) sets the clock path.
// Reset clears the stage valids and loads the register reset values.
// A stall on m_axis fills the empty stages first; s_axis_tready drops only
// when all four stages hold a pixel. cfg_ready is always high.
`default_nettype none

module shape_coverage_alpha_blend (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // [9:0] pixel_x, [19:10] pixel_y, [27:20] background_red,
    // [35:28] background_green, [43:36] background_blue, [47:44] zero
    input  wire  [47:0]                  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue
    output logic [23:0]                  m_axis_tdata,
    // [0] covered
    output logic                         m_axis_tuser,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [sca_pkg::IDX_W-1:0]    cfg_index,
    input  wire  [sca_pkg::DATA_W-1:0]   cfg_data
);
    import sca_pkg::*;

    `include "assert_macros.svh"

    sca_cfg_t  cfg;
    sca_pipe_t ctrl;

    logic v1_reg, v2_reg, v3_reg, vout_reg;
    logic hit;
    logic [7:0] res_r, res_g, res_b;
    logic res_cov;

    // Register file
    sca_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign cfg_ready = 1'b1;

    // Stage enables: a stage loads when empty or when the next one loads
    always_comb
    begin
        ctrl.en_out = !vout_reg || m_axis_tready;
        ctrl.en3    = !v3_reg || ctrl.en_out;
        ctrl.en2    = !v2_reg || ctrl.en3;
        ctrl.en1    = !v1_reg || ctrl.en2;
        ctrl.v3     = v3_reg;
    end

    assign s_axis_tready = ctrl.en1;

    // Advance valids along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.en1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (ctrl.en2)
            begin
                v2_reg <= v1_reg;
            end
            if (ctrl.en3)
            begin
                v3_reg <= v2_reg;
            end
            if (ctrl.en_out)
            begin
                vout_reg <= v3_reg;
            end
        end
    end

    // Coverage test
    sca_coverage u_coverage (
        .clk     (clk),
        .ctrl    (ctrl),
        .cfg     (cfg),
        .pixel_x (s_axis_tdata[9:0]),
        .pixel_y (s_axis_tdata[19:10]),
        .hit     (hit)
    );

    // Blend and output registers
    sca_blend u_blend (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .cfg              (cfg),
        .background_red   (s_axis_tdata[27:20]),
        .background_green (s_axis_tdata[35:28]),
        .background_blue  (s_axis_tdata[43:36]),
        .hit              (hit),
        .out_red          (res_r),
        .out_green        (res_g),
        .out_blue         (res_b),
        .covered          (res_cov)
    );

    assign m_axis_tvalid = vout_reg;
    assign m_axis_tdata  = {res_b, res_g, res_r};
    assign m_axis_tuser  = res_cov;

    // Input is refused only with every stage full and the output stalled
    `SCA_ASSERT(a_full_stall, clk, rst_n, !s_axis_tready |-> (v1_reg && v2_reg && v3_reg && vout_reg && !m_axis_tready), "input refused while pipeline has room")

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for shape_coverage_alpha_blend: pixel stream in,
// blended color stream out, checked against an in-bench coverage and blend predictor.
// Depends on sca_pkg and the shape_coverage_alpha_blend RTL.
`default_nettype none

module tb_top;

    import sca_pkg::*;

    // Expected color and coverage of one pixel
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               covered;
    } pixel_color_t;

    // Receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int PRINT_LIMIT    = 40;
    localparam int RANDOM_PHASES  = 14;
    localparam int PHASE_PIXELS   = 125;
    localparam int DRAIN_SLACK    = 8;

    // Blend predictor and pending-pixel store
    class pixel_blend_scoreboard;
        sca_cfg_t     regs;
        pixel_color_t pending_q[$];
        int           errors;
        int           results_seen;
        int           covered_seen;
        int           settings_seen;

        function new();
            regs          = '0;
            regs.rot_cos  = COS_ONE;
            errors        = 0;
            results_seen  = 0;
            covered_seen  = 0;
            settings_seen = 0;
        endfunction

        // Keep only the register's width of low bits
        function void write_reg(sca_reg_idx_t idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_SHAPE_MODE: regs.shape_mode = data[0];
                REG_CENTER_X:   regs.center_x   = data[15:0];
                REG_CENTER_Y:   regs.center_y   = data[15:0];
                REG_EXTENT_A:   regs.extent_a   = data[14:0];
                REG_EXTENT_B:   regs.extent_b   = data[14:0];
                REG_ROT_COS:    regs.rot_cos    = data[15:0];
                REG_ROT_SIN:    regs.rot_sin    = data[15:0];
                REG_PAINT:      regs.paint      = data;
                default:        ;
            endcase
        endfunction

        function logic [COLOR_W-1:0] blend_channel(int src, int dst, int alpha);
            return COLOR_W'((src * alpha + dst * (int'(ALPHA_MAX) - alpha))
                            / int'(ALPHA_MAX));
        endfunction

        // Test the pixel center against the shape, then blend or pass through
        function pixel_color_t coverage_color(logic [47:0] pix);
            longint       px, py, c, s, lx, ly, ha, hb, d2;
            int           alpha;
            logic         hit;
            pixel_color_t res;
            hit         = 1'b0;
            res.red     = pix[27:20];
            res.green   = pix[35:28];
            res.blue    = pix[43:36];
            res.covered = 1'b0;
            if (pix[9:0] < FRAME_WIDTH && pix[19:10] < FRAME_HEIGHT) begin
                px = longint'(pix[9:0]) * 16 + 8 - longint'($signed(regs.center_x));
                py = longint'(pix[19:10]) * 16 + 8 - longint'($signed(regs.center_y));
                if (regs.shape_mode == SHAPE_RING) begin
                    d2  = px * px + py * py;
                    hit = d2 <= longint'(regs.extent_a) * longint'(regs.extent_a) &&
                          d2 >= longint'(regs.extent_b) * longint'(regs.extent_b);
                end
                else begin
                    c   = longint'($signed(regs.rot_cos));
                    s   = longint'($signed(regs.rot_sin));
                    lx  = px * c - py * s;
                    ly  = px * s + py * c;
                    ha  = longint'(regs.extent_a) * longint'(COS_ONE);
                    hb  = longint'(regs.extent_b) * longint'(COS_ONE);
                    hit = lx >= -ha && lx <= ha && ly >= -hb && ly <= hb;
                end
            end
            if (hit) begin
                alpha       = int'(regs.paint[7:0]);
                res.red     = blend_channel(int'(regs.paint[31:24]), int'(pix[27:20]), alpha);
                res.green   = blend_channel(int'(regs.paint[23:16]), int'(pix[35:28]), alpha);
                res.blue    = blend_channel(int'(regs.paint[15:8]),  int'(pix[43:36]), alpha);
                res.covered = 1'b1;
            end
            return res;
        endfunction

        function void note_pixel(logic [47:0] pix);
            pending_q.push_back(coverage_color(pix));
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("ERROR result %0d: %s", results_seen, msg);
        endtask

        // Compare one output transaction with the oldest pending pixel
        task check_result(logic [23:0] data, logic cov);
            pixel_color_t want;
            if (pending_q.size() == 0) begin
                report_mismatch("result with no pixel pending");
                return;
            end
            want = pending_q.pop_front();
            results_seen++;
            if (cov)
                covered_seen++;
            if (data[7:0] != want.red)
                report_mismatch($sformatf("red got %0d want %0d", data[7:0], want.red));
            if (data[15:8] != want.green)
                report_mismatch($sformatf("green got %0d want %0d", data[15:8], want.green));
            if (data[23:16] != want.blue)
                report_mismatch($sformatf("blue got %0d want %0d", data[23:16], want.blue));
            if (cov != want.covered)
                report_mismatch($sformatf("covered got %0b want %0b", cov, want.covered));
        endtask
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [47:0]         s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [23:0]         m_axis_tdata;
    logic                m_axis_tuser;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index     = '0;
    logic [DATA_W-1:0]   cfg_data      = '0;

    pixel_blend_scoreboard sb = new();
    logic [47:0]           pixel_q[$];
    int                    cycle_count = 0;
    rx_mode_t              rx_mode     = RX_OPEN;
    int                    rx_left     = 0;
    int                    cos_tab[8]  = '{16384, 0, -16384, 0, 11585, 11585, 14189, 8192};
    int                    sin_tab[8]  = '{0, 16384, 0, -16384, 11585, -11585, 8192, -14189};

    shape_coverage_alpha_blend dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Free-running clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stall the output side on a changing pattern
    always @(negedge clk)
    begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 300);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_axis_tready <= (rx_left % 5 == 0);
            default:     m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Check every output transaction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    function automatic sca_cfg_t make_cfg(logic mode, logic [15:0] cx, logic [15:0] cy,
                                          logic [14:0] ea, logic [14:0] eb,
                                          logic [15:0] rc, logic [15:0] rs,
                                          logic [31:0] paint);
        sca_cfg_t c;
        c.shape_mode = mode;
        c.center_x   = cx;
        c.center_y   = cy;
        c.extent_a   = ea;
        c.extent_b   = eb;
        c.rot_cos    = rc;
        c.rot_sin    = rs;
        c.paint      = paint;
        return c;
    endfunction

    function automatic void push_pixel(int x, int y, int r, int g, int b);
        pixel_q.push_back({4'b0, b[7:0], g[7:0], r[7:0], y[9:0], x[9:0]});
    endfunction

    // Hold until every pending pixel has come back
    task automatic wait_drained();
        while (sb.pending_q.size() != 0)
            @(negedge clk);
    endtask

    // Write all registers while idle, with junk above each register's width
    task automatic apply_cfg(input sca_cfg_t c);
        logic [DATA_W-1:0] value[8];
        wait_drained();
        value[REG_SHAPE_MODE] = ($urandom() & 32'hFFFF_FFFE) | {31'b0, c.shape_mode};
        value[REG_CENTER_X]   = ($urandom() & 32'hFFFF_0000) | {16'b0, c.center_x};
        value[REG_CENTER_Y]   = ($urandom() & 32'hFFFF_0000) | {16'b0, c.center_y};
        value[REG_EXTENT_A]   = ($urandom() & 32'hFFFF_8000) | {17'b0, c.extent_a};
        value[REG_EXTENT_B]   = ($urandom() & 32'hFFFF_8000) | {17'b0, c.extent_b};
        value[REG_ROT_COS]    = ($urandom() & 32'hFFFF_0000) | {16'b0, c.rot_cos};
        value[REG_ROT_SIN]    = ($urandom() & 32'hFFFF_0000) | {16'b0, c.rot_sin};
        value[REG_PAINT]      = c.paint;
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= sca_reg_idx_t'(i);
            cfg_data  <= value[i];
            do @(posedge clk); while (!cfg_ready);
            sb.write_reg(sca_reg_idx_t'(i), value[i]);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        sb.settings_seen++;
    endtask

    // Drive the queued pixels in bursts with random gaps
    task automatic flush_pixels();
        int burst;
        int gap;
        while (pixel_q.size() != 0) begin
            burst = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            while (burst > 0 && pixel_q.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixel_q[0];
                do @(posedge clk); while (!s_axis_tready);
                sb.note_pixel(pixel_q.pop_front());
                @(negedge clk);
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // One random shape setting with pixels aimed mostly around the shape
    task automatic run_random_phase(input int n_pixels, input bit drain_mid);
        sca_cfg_t c;
        int       ea, eb, reach, cx_pix, cy_pix, x, y, k;
        c.shape_mode = 1'($urandom_range(0, 1));
        c.center_x   = 16'($urandom_range(0, 1023) * 16 + $urandom_range(0, 15));
        c.center_y   = 16'($urandom_range(0, 1023) * 16 + $urandom_range(0, 15));
        if ($urandom_range(0, 7) == 0) begin
            c.center_x = 16'($urandom());
            c.center_y = 16'($urandom());
        end
        case ($urandom_range(0, 9))
            0:       ea = 0;
            1:       ea = 32767;
            default: ea = $urandom_range(8, 640);
        endcase
        if (c.shape_mode == SHAPE_RING && $urandom_range(0, 4) != 0)
            eb = $urandom_range(0, ea);
        else
            eb = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(8, 700);
        c.extent_a = 15'(ea);
        c.extent_b = 15'(eb);
        k = $urandom_range(0, 7);
        c.rot_cos = 16'(cos_tab[k]);
        c.rot_sin = 16'(sin_tab[k]);
        if ($urandom_range(0, 3) == 0) begin
            c.rot_cos = 16'(int'($urandom_range(0, 32768)) - 16384);
            c.rot_sin = 16'(int'($urandom_range(0, 32768)) - 16384);
        end
        else if ($urandom_range(0, 9) == 0) begin
            c.rot_cos = 16'($urandom());
            c.rot_sin = 16'($urandom());
        end
        c.paint = $urandom();
        case ($urandom_range(0, 5))
            0:       c.paint[7:0] = '0;
            1:       c.paint[7:0] = ALPHA_MAX;
            default: ;
        endcase
        apply_cfg(c);

        cx_pix = int'($signed(c.center_x)) >>> 4;
        cy_pix = int'($signed(c.center_y)) >>> 4;
        cx_pix = (cx_pix < 0) ? 0 : cx_pix;
        cy_pix = (cy_pix < 0) ? 0 : cy_pix;
        reach  = ((ea > eb) ? ea : eb) / 16 + 4;
        reach  = (reach > 1023) ? 1023 : reach;
        for (int i = 0; i < n_pixels; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                x = $urandom_range(0, 1023);
                y = $urandom_range(0, 1023);
            end
            else begin
                x = cx_pix + int'($urandom_range(0, 2 * reach)) - reach;
                y = cy_pix + int'($urandom_range(0, 2 * reach)) - reach;
                x = (x < 0) ? 0 : ((x > 1023) ? 1023 : x);
                y = (y < 0) ? 0 : ((y > 1023) ? 1023 : y);
            end
            push_pixel(x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255));
            if (drain_mid && i == n_pixels / 2) begin
                flush_pixels();
                wait_drained();
            end
        end
        flush_pixels();
    endtask

    // Main sequence
    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: zero-size rectangle at the origin, nothing covered
        push_pixel(0, 0, 0, 0, 0);
        push_pixel(1023, 1023, 255, 255, 255);
        flush_pixels();

        // Axis-aligned rectangle, full alpha: edges on both axes count as inside
        apply_cfg(make_cfg(SHAPE_RECT, 16'd88, 16'd88, 15'd32, 15'd16,
                           COS_ONE, 16'd0, 32'hFF00_80FF));
        push_pixel(7, 5, 0, 255, 0);
        push_pixel(8, 5, 255, 0, 255);
        push_pixel(3, 5, 255, 255, 255);
        push_pixel(2, 5, 0, 0, 0);
        push_pixel(5, 6, 12, 200, 99);
        push_pixel(5, 7, 0, 0, 0);
        push_pixel(5, 4, 255, 255, 0);
        flush_pixels();

        // Extreme centers and extents, cos/sin outside unit range, zero alpha
        apply_cfg(make_cfg(SHAPE_RECT, 16'h7FFF, 16'h8000, 15'h7FFF, 15'h7FFF,
                           16'h8000, 16'h7FFF, 32'hFFFF_FF00));
        push_pixel(5, 5, 1, 2, 3);
        push_pixel(6, 5, 255, 128, 0);
        push_pixel(0, 0, 0, 0, 0);
        push_pixel(1023, 0, 255, 255, 255);
        flush_pixels();

        // Ring around the first pixel center: both radii are inclusive
        apply_cfg(make_cfg(SHAPE_RING, 16'd8, 16'd8, 15'd48, 15'd32,
                           COS_ONE, 16'd0, 32'h40C0_2080));
        push_pixel(3, 0, 200, 10, 255);
        push_pixel(4, 0, 200, 10, 255);
        push_pixel(2, 0, 0, 255, 77);
        push_pixel(1, 0, 0, 255, 77);
        push_pixel(0, 0, 255, 0, 0);
        push_pixel(0, 2, 33, 66, 99);
        flush_pixels();

        // Inner radius above outer: nothing covered
        apply_cfg(make_cfg(SHAPE_RING, 16'd8, 16'd8, 15'd16, 15'd48,
                           COS_ONE, 16'd0, 32'hFFFF_FFFF));
        push_pixel(0, 0, 5, 5, 5);
        push_pixel(2, 0, 6, 6, 6);
        flush_pixels();

        // Zero radii: only a center exactly on a pixel center is covered
        apply_cfg(make_cfg(SHAPE_RING, 16'd8, 16'd8, 15'd0, 15'd0,
                           COS_ONE, 16'd0, 32'h1234_56A0));
        push_pixel(0, 0, 250, 3, 128);
        push_pixel(1, 0, 250, 3, 128);
        flush_pixels();

        // Random settings, one of them paused for a full drain mid-stream
        for (int p = 0; p < RANDOM_PHASES; p++)
            run_random_phase(PHASE_PIXELS, p == 5);

        wait_drained();
        repeat (DRAIN_SLACK) @(negedge clk);
        if (sb.pending_q.size() != 0)
            sb.report_mismatch($sformatf("%0d pixels left without a result",
                                         sb.pending_q.size()));

        $display("Checked %0d pixels, %0d covered, over %0d shape settings",
                 sb.results_seen, sb.covered_seen, sb.settings_seen + 1);
        $display("Rectangle and ring edges, extreme registers, then random shapes and stalls");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

### shape_coverage_alpha_blend.f
+incdir+src
src/sca_pkg.sv
src/sca_cfg_regs.sv
src/sca_coverage.sv
src/sca_blend.sv
src/shape_coverage_alpha_blend.sv
verif/tb_top.sv
